/* sv/sscp_pkg.sv */
// ----------------------------------------------------------------------------
// Segment closest points package
// Quotient format shared by the top level and the pipelined divider.
// ----------------------------------------------------------------------------
package sscp_pkg;

	localparam int QBITS = 16;
	localparam int QW = QBITS + 1;
	localparam int QSTAGES = QBITS + 1;
	localparam logic [QW-1:0] QONE = QW'(1) << QBITS;

endpackage

/* sv/sscp_qdiv.sv */
// ----------------------------------------------------------------------------
// Pipelined clamped quotient
// Returns num/den in Q1.16, clamped to zero and one, one quotient bit a stage.
// ----------------------------------------------------------------------------
module sscp_qdiv
	import sscp_pkg::*;
#(
	parameter int WIDTH = 70
) (
	input  logic                    clk,
	input  logic [QSTAGES-1:0]      en,
	input  logic signed [WIDTH-1:0] num,
	input  logic signed [WIDTH-1:0] den,
	output logic [QW-1:0]           quo
);

	logic [WIDTH-1:0] rem_q [QSTAGES];
	logic [WIDTH-1:0] den_q [QSTAGES];
	logic [QBITS-1:0] quo_q [QSTAGES];
	logic             zero_q [QSTAGES];
	logic             full_q [QSTAGES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_q[0]  <= num;
			den_q[0]  <= den;
			quo_q[0]  <= '0;
			zero_q[0] <= num[WIDTH-1] || (num == '0);
			full_q[0] <= !(num < den);
		end
	end

	for (genvar i = 1; i < QSTAGES; i++) begin : g_step
		logic [WIDTH-1:0] dbl;
		logic             ge;

		assign dbl = {rem_q[i-1][WIDTH-2:0], 1'b0};
		assign ge = dbl >= den_q[i-1];

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_q[i]  <= ge ? dbl - den_q[i-1] : dbl;
				den_q[i]  <= den_q[i-1];
				quo_q[i]  <= {quo_q[i-1][QBITS-2:0], ge};
				zero_q[i] <= zero_q[i-1];
				full_q[i] <= full_q[i-1];
			end
		end
	end

	assign quo = zero_q[QSTAGES-1] ? '0 :
		full_q[QSTAGES-1] ? QONE : {1'b0, quo_q[QSTAGES-1]};

endmodule

/* sv/segment_segment_closest_points_unit.sv */
// ----------------------------------------------------------------------------
// Segment to segment closest points
// Closest points, clamped parameters and squared distance of two 3D segments.
// ----------------------------------------------------------------------------
//  channel  | signals                               | transaction
//  seg      | seg_valid, seg_ready, seg1_*, seg2_*  | end points of two segments
//  res      | res_valid, res_ready, param_*, ...    | s, t, points, distance
//  apb      | psel, penable, pwrite, paddr, ...     | threshold register
//
//  One transaction is taken in every cycle while the result channel does not stall.
//  The pipeline holds two chains of 17 divider stages in series.
//  Reset clears the valid bits and sets the threshold to one.
//  A stall fills empty stages first; ready falls only when every stage is full.
// ----------------------------------------------------------------------------
module segment_segment_closest_points_unit
	import sscp_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_ready,
	input  logic signed [31:0] seg1_start_x,
	input  logic signed [31:0] seg1_start_y,
	input  logic signed [31:0] seg1_start_z,
	input  logic signed [31:0] seg1_end_x,
	input  logic signed [31:0] seg1_end_y,
	input  logic signed [31:0] seg1_end_z,
	input  logic signed [31:0] seg2_start_x,
	input  logic signed [31:0] seg2_start_y,
	input  logic signed [31:0] seg2_start_z,
	input  logic signed [31:0] seg2_end_x,
	input  logic signed [31:0] seg2_end_y,
	input  logic signed [31:0] seg2_end_z,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [16:0]        param_s,
	output logic [16:0]        param_t,
	output logic signed [31:0] near1_x,
	output logic signed [31:0] near1_y,
	output logic signed [31:0] near1_z,
	output logic signed [31:0] near2_x,
	output logic signed [31:0] near2_y,
	output logic signed [31:0] near2_z,
	output logic [31:0]        dist_squared,
	output logic [2:0]         case_code,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CW = 32;
	localparam int DFW = CW + 1;
	localparam int PW = 2 * DFW;
	localparam int DW = PW + 2;
	localparam int HW = DW / 2;
	localparam int PPW = 2 * HW + 2;
	localparam int WW = 2 * DW + 1;
	localparam int BW = DW + 1;
	localparam int TPW = HW + QW + 2;
	localparam int TW = DW + QW + 1;
	localparam int VW = DFW + QW + 1;
	localparam int QHALF = 1 << (QBITS - 1);
	localparam int TW_W = 16;

	localparam int DA0 = 7;
	localparam int DA1 = DA0 + QSTAGES - 1;
	localparam int DE0 = DA1 + 3;
	localparam int DE1 = DE0 + QSTAGES - 1;
	localparam int NST = DE1 + 4;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef enum logic [2:0] {
		CASE_BOTH     = 3'd0,
		CASE_FIRST    = 3'd1,
		CASE_SECOND   = 3'd2,
		CASE_PARALLEL = 3'd3,
		CASE_GENERAL  = 3'd4
	} case_t;

	typedef logic signed [CW-1:0]  crd_t;
	typedef logic signed [DFW-1:0] dif_t;
	typedef logic signed [PW-1:0]  prod_t;
	typedef logic signed [DW-1:0]  dot_t;
	typedef logic signed [PPW-1:0] pprod_t;
	typedef logic signed [WW-1:0]  wide_t;
	typedef logic signed [BW-1:0]  lane_t;
	typedef logic signed [TW-1:0]  tn_t;
	typedef logic signed [TPW-1:0] tpp_t;
	typedef logic signed [VW-1:0]  scl_t;

	typedef struct {
		crd_t p1 [3];
		crd_t p2 [3];
		dif_t d1 [3];
		dif_t d2 [3];
	} geo_t;

	typedef struct {
		pprod_t hh;
		pprod_t hl;
		pprod_t lh;
		pprod_t ll;
	} pp_t;

	typedef struct {
		geo_t  g;
		dot_t  b;
		dot_t  e;
		dot_t  f;
		case_t code;
	} mid_t;

	typedef struct {
		geo_t          g;
		case_t         code;
		logic [QW-1:0] qa;
		logic [QW-1:0] qb;
		logic [QW-1:0] qc;
		logic          neg;
		logic          gt;
	} end_t;

	function automatic pp_t split_mul(dot_t x, dot_t y);
		pp_t p;
		logic signed [HW-1:0] xh;
		logic signed [HW-1:0] yh;
		logic signed [HW:0]   xl;
		logic signed [HW:0]   yl;
		xh = x[DW-1:HW];
		yh = y[DW-1:HW];
		xl = {1'b0, x[HW-1:0]};
		yl = {1'b0, y[HW-1:0]};
		p.hh = xh * yh;
		p.hl = xh * yl;
		p.lh = xl * yh;
		p.ll = xl * yl;
		return p;
	endfunction

	function automatic wide_t pp_sum(pp_t p);
		return (wide_t'(p.hh) <<< (2 * HW)) + ((wide_t'(p.hl) + wide_t'(p.lh)) <<< HW)
			+ wide_t'(p.ll);
	endfunction

	// Handshake and valid chain.
	logic [NST:1] en;
	logic [NST:1] vld_q;
	logic [NST:1] vld_in;

	assign en[NST] = !vld_q[NST] || res_ready;
	for (genvar k = 1; k < NST; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end
	assign vld_in = {vld_q[NST-1:1], seg_valid};
	assign seg_ready = en[1];
	assign res_valid = vld_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// Configuration register.
	logic [TW_W-1:0] thr_q;
	logic [DW-1:0]   thr_w;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? CW'(thr_q) : '0;
	assign thr_w = DW'(thr_q) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= TW_W'(1);
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			thr_q <= pwdata[TW_W-1:0];
		end
	end

	crd_t p1_w [3];
	crd_t q1_w [3];
	crd_t p2_w [3];
	crd_t q2_w [3];

	assign p1_w[0] = seg1_start_x;
	assign p1_w[1] = seg1_start_y;
	assign p1_w[2] = seg1_start_z;
	assign q1_w[0] = seg1_end_x;
	assign q1_w[1] = seg1_end_y;
	assign q1_w[2] = seg1_end_z;
	assign p2_w[0] = seg2_start_x;
	assign p2_w[1] = seg2_start_y;
	assign p2_w[2] = seg2_start_z;
	assign q2_w[0] = seg2_end_x;
	assign q2_w[1] = seg2_end_y;
	assign q2_w[2] = seg2_end_z;

	// Stage 1: direction vectors.
	geo_t geo_s1;
	dif_t r_s1 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 3; k++) begin
				geo_s1.p1[k] <= p1_w[k];
				geo_s1.p2[k] <= p2_w[k];
				geo_s1.d1[k] <= dif_t'(q1_w[k]) - dif_t'(p1_w[k]);
				geo_s1.d2[k] <= dif_t'(q2_w[k]) - dif_t'(p2_w[k]);
				r_s1[k] <= dif_t'(p1_w[k]) - dif_t'(p2_w[k]);
			end
		end
	end

	// Stage 2: component products for the dot products.
	geo_t  geo_s2;
	prod_t pa_s2 [3];
	prod_t pe_s2 [3];
	prod_t pf_s2 [3];
	prod_t pc_s2 [3];
	prod_t pb_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			geo_s2 <= geo_s1;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= geo_s1.d1[k] * geo_s1.d1[k];
				pe_s2[k] <= geo_s1.d2[k] * geo_s1.d2[k];
				pf_s2[k] <= geo_s1.d2[k] * r_s1[k];
				pc_s2[k] <= geo_s1.d1[k] * r_s1[k];
				pb_s2[k] <= geo_s1.d1[k] * geo_s1.d2[k];
			end
		end
	end

	// Stage 3: dot products.
	geo_t geo_s3;
	dot_t a_s3, e_s3, f_s3, c_s3, b_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			geo_s3 <= geo_s2;
			a_s3 <= DW'(pa_s2[0]) + DW'(pa_s2[1]) + DW'(pa_s2[2]);
			e_s3 <= DW'(pe_s2[0]) + DW'(pe_s2[1]) + DW'(pe_s2[2]);
			f_s3 <= DW'(pf_s2[0]) + DW'(pf_s2[1]) + DW'(pf_s2[2]);
			c_s3 <= DW'(pc_s2[0]) + DW'(pc_s2[1]) + DW'(pc_s2[2]);
			b_s3 <= DW'(pb_s2[0]) + DW'(pb_s2[1]) + DW'(pb_s2[2]);
		end
	end

	// Stage 4: point tests and partial products of the wide terms.
	geo_t geo_s4;
	dot_t a_s4, e_s4, f_s4, c_s4, b_s4;
	logic ap_s4, ep_s4;
	pp_t  pp_ae_s4, pp_bb_s4, pp_bf_s4, pp_ce_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			geo_s4 <= geo_s3;
			a_s4 <= a_s3;
			e_s4 <= e_s3;
			f_s4 <= f_s3;
			c_s4 <= c_s3;
			b_s4 <= b_s3;
			ap_s4 <= $unsigned(a_s3) <= thr_w;
			ep_s4 <= $unsigned(e_s3) <= thr_w;
			pp_ae_s4 <= split_mul(a_s3, e_s3);
			pp_bb_s4 <= split_mul(b_s3, b_s3);
			pp_bf_s4 <= split_mul(b_s3, f_s3);
			pp_ce_s4 <= split_mul(c_s3, e_s3);
		end
	end

	// Stage 5: wide products.
	geo_t  geo_s5;
	dot_t  a_s5, e_s5, f_s5, c_s5, b_s5;
	logic  ap_s5, ep_s5;
	wide_t ae_s5, bb_s5, bf_s5, ce_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			geo_s5 <= geo_s4;
			a_s5 <= a_s4;
			e_s5 <= e_s4;
			f_s5 <= f_s4;
			c_s5 <= c_s4;
			b_s5 <= b_s4;
			ap_s5 <= ap_s4;
			ep_s5 <= ep_s4;
			ae_s5 <= pp_sum(pp_ae_s4);
			bb_s5 <= pp_sum(pp_bb_s4);
			bf_s5 <= pp_sum(pp_bf_s4);
			ce_s5 <= pp_sum(pp_ce_s4);
		end
	end

	// Stage 6: case decision and divider operands.
	wide_t denom, numer;
	case_t code;
	geo_t  geo_s6;
	dot_t  e_s6, f_s6, b_s6;
	case_t code_s6;
	wide_t na_s6, da_s6;
	lane_t nb_s6, db_s6, nc_s6, dc_s6;

	assign denom = ae_s5 - bb_s5;
	assign numer = bf_s5 - ce_s5;

	always_comb begin
		if (ap_s5 && ep_s5) begin
			code = CASE_BOTH;
		end else if (ap_s5) begin
			code = CASE_FIRST;
		end else if (ep_s5) begin
			code = CASE_SECOND;
		end else if (denom == '0) begin
			code = CASE_PARALLEL;
		end else begin
			code = CASE_GENERAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			geo_s6 <= geo_s5;
			e_s6 <= e_s5;
			f_s6 <= f_s5;
			b_s6 <= b_s5;
			code_s6 <= code;
			na_s6 <= (code == CASE_FIRST) ? wide_t'(f_s5) : numer;
			da_s6 <= (code == CASE_FIRST) ? wide_t'(e_s5) : denom;
			nb_s6 <= -lane_t'(c_s5);
			db_s6 <= lane_t'(a_s5);
			nc_s6 <= lane_t'(b_s5) - lane_t'(c_s5);
			dc_s6 <= lane_t'(a_s5);
		end
	end

	// First divider window.
	mid_t          mid_s [DA0:DA1];
	logic [QW-1:0] qa, qb, qc, qe;

	always_ff @(posedge clk) begin
		if (en[DA0]) begin
			mid_s[DA0].g <= geo_s6;
			mid_s[DA0].b <= b_s6;
			mid_s[DA0].e <= e_s6;
			mid_s[DA0].f <= f_s6;
			mid_s[DA0].code <= code_s6;
		end
	end

	for (genvar k = DA0 + 1; k <= DA1; k++) begin : g_mid
		always_ff @(posedge clk) begin
			if (en[k]) begin
				mid_s[k] <= mid_s[k-1];
			end
		end
	end

	sscp_qdiv #(.WIDTH(WW)) u_div_a (
		.clk (clk),
		.en  (en[DA1:DA0]),
		.num (na_s6),
		.den (da_s6),
		.quo (qa)
	);

	sscp_qdiv #(.WIDTH(BW)) u_div_b (
		.clk (clk),
		.en  (en[DA1:DA0]),
		.num (nb_s6),
		.den (db_s6),
		.quo (qb)
	);

	sscp_qdiv #(.WIDTH(BW)) u_div_c (
		.clk (clk),
		.en  (en[DA1:DA0]),
		.num (nc_s6),
		.den (dc_s6),
		.quo (qc)
	);

	// Stage 24: partial products of b times the first s.
	logic [QW-1:0]        s0;
	logic signed [QW:0]   s0_sg;
	logic signed [HW-1:0] bh;
	logic signed [HW:0]   bl;
	end_t                 x_s24;
	dot_t                 e_s24, f_s24;
	tpp_t                 ph_s24, pl_s24;

	assign s0 = (mid_s[DA1].code == CASE_PARALLEL) ? '0 : qa;
	assign s0_sg = {1'b0, s0};
	assign bh = mid_s[DA1].b[DW-1:HW];
	assign bl = {1'b0, mid_s[DA1].b[HW-1:0]};

	always_ff @(posedge clk) begin
		if (en[DA1+1]) begin
			x_s24.g <= mid_s[DA1].g;
			x_s24.code <= mid_s[DA1].code;
			x_s24.qa <= qa;
			x_s24.qb <= qb;
			x_s24.qc <= qc;
			x_s24.neg <= 1'b0;
			x_s24.gt <= 1'b0;
			e_s24 <= mid_s[DA1].e;
			f_s24 <= mid_s[DA1].f;
			ph_s24 <= bh * s0_sg;
			pl_s24 <= bl * s0_sg;
		end
	end

	// Stage 25: numerator and denominator of t.
	end_t x_s25;
	tn_t  tn_s25, eq_s25;

	always_ff @(posedge clk) begin
		if (en[DA1+2]) begin
			x_s25 <= x_s24;
			tn_s25 <= (tn_t'(ph_s24) <<< HW) + tn_t'(pl_s24) + (tn_t'(f_s24) <<< QBITS);
			eq_s25 <= tn_t'(e_s24) <<< QBITS;
		end
	end

	// Second divider window.
	end_t end_s [DE0:DE1];

	always_ff @(posedge clk) begin
		if (en[DE0]) begin
			end_s[DE0].g <= x_s25.g;
			end_s[DE0].code <= x_s25.code;
			end_s[DE0].qa <= x_s25.qa;
			end_s[DE0].qb <= x_s25.qb;
			end_s[DE0].qc <= x_s25.qc;
			end_s[DE0].neg <= tn_s25[TW-1];
			end_s[DE0].gt <= eq_s25 < tn_s25;
		end
	end

	for (genvar k = DE0 + 1; k <= DE1; k++) begin : g_end
		always_ff @(posedge clk) begin
			if (en[k]) begin
				end_s[k] <= end_s[k-1];
			end
		end
	end

	sscp_qdiv #(.WIDTH(TW)) u_div_e (
		.clk (clk),
		.en  (en[DE1:DE0]),
		.num (tn_s25),
		.den (eq_s25),
		.quo (qe)
	);

	// Stage 43: final parameters and scaled directions.
	logic [QW-1:0]      sel_s, sel_t;
	logic signed [QW:0] s_sg, t_sg;
	end_t               xe;
	crd_t               p1_s43 [3];
	crd_t               p2_s43 [3];
	scl_t               v1_s43 [3];
	scl_t               v2_s43 [3];
	logic [QW-1:0]      s_s43, t_s43;
	case_t              code_s43;

	assign xe = end_s[DE1];

	always_comb begin
		case (xe.code) inside
			CASE_BOTH: begin
				sel_s = '0;
				sel_t = '0;
			end
			CASE_FIRST: begin
				sel_s = '0;
				sel_t = xe.qa;
			end
			CASE_SECOND: begin
				sel_s = xe.qb;
				sel_t = '0;
			end
			CASE_PARALLEL, CASE_GENERAL: begin
				sel_t = qe;
				if (xe.neg) begin
					sel_s = xe.qb;
				end else if (xe.gt) begin
					sel_s = xe.qc;
				end else begin
					sel_s = (xe.code == CASE_PARALLEL) ? '0 : xe.qa;
				end
			end
			default: begin
				sel_s = '0;
				sel_t = '0;
			end
		endcase
	end

	assign s_sg = {1'b0, sel_s};
	assign t_sg = {1'b0, sel_t};

	always_ff @(posedge clk) begin
		if (en[DE1+1]) begin
			s_s43 <= sel_s;
			t_s43 <= sel_t;
			code_s43 <= xe.code;
			for (int k = 0; k < 3; k++) begin
				p1_s43[k] <= xe.g.p1[k];
				p2_s43[k] <= xe.g.p2[k];
				v1_s43[k] <= xe.g.d1[k] * s_sg;
				v2_s43[k] <= xe.g.d2[k] * t_sg;
			end
		end
	end

	// Stage 44: closest points, rounded half up.
	crd_t          n1_s44 [3];
	crd_t          n2_s44 [3];
	logic [QW-1:0] s_s44, t_s44;
	case_t         code_s44;

	always_ff @(posedge clk) begin
		if (en[DE1+2]) begin
			s_s44 <= s_s43;
			t_s44 <= t_s43;
			code_s44 <= code_s43;
			for (int k = 0; k < 3; k++) begin
				n1_s44[k] <= p1_s43[k] + CW'((v1_s43[k] + VW'(QHALF)) >>> QBITS);
				n2_s44[k] <= p2_s43[k] + CW'((v2_s43[k] + VW'(QHALF)) >>> QBITS);
			end
		end
	end

	// Stage 45: squared differences.
	dif_t          g_w [3];
	prod_t         sq_s45 [3];
	crd_t          n1_s45 [3];
	crd_t          n2_s45 [3];
	logic [QW-1:0] s_s45, t_s45;
	case_t         code_s45;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			g_w[k] = dif_t'(n1_s44[k]) - dif_t'(n2_s44[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[DE1+3]) begin
			s_s45 <= s_s44;
			t_s45 <= t_s44;
			code_s45 <= code_s44;
			for (int k = 0; k < 3; k++) begin
				n1_s45[k] <= n1_s44[k];
				n2_s45[k] <= n2_s44[k];
				sq_s45[k] <= g_w[k] * g_w[k];
			end
		end
	end

	// Stage 46: distance, scaled and saturated, into the output register.
	logic [DW-1:0] sqsum, sqsh;
	crd_t          n1_s46 [3];
	crd_t          n2_s46 [3];
	logic [QW-1:0] s_s46, t_s46;
	case_t         code_s46;
	logic [CW-1:0] dist_s46;

	assign sqsum = DW'(sq_s45[0]) + DW'(sq_s45[1]) + DW'(sq_s45[2]);
	assign sqsh = sqsum >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			s_s46 <= s_s45;
			t_s46 <= t_s45;
			code_s46 <= code_s45;
			n1_s46 <= n1_s45;
			n2_s46 <= n2_s45;
			dist_s46 <= (|sqsh[DW-1:CW]) ? '1 : sqsh[CW-1:0];
		end
	end

	assign param_s = s_s46;
	assign param_t = t_s46;
	assign near1_x = n1_s46[0];
	assign near1_y = n1_s46[1];
	assign near1_z = n1_s46[2];
	assign near2_x = n2_s46[0];
	assign near2_y = n2_s46[1];
	assign near2_z = n2_s46[2];
	assign dist_squared = dist_s46;
	assign case_code = code_s46;

`ifndef SYNTHESIS
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!seg_ready |-> (res_valid && !res_ready))
		else $error("input stalled while the pipeline has room");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (param_s <= QONE && param_t <= QONE))
		else $error("segment parameter above one");

	a_point_params: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((case_code != CASE_BOTH && case_code != CASE_FIRST) || param_s == '0)
			&& ((case_code != CASE_BOTH && case_code != CASE_SECOND) || param_t == '0))
		else $error("point segment with non-zero parameter");
`endif

endmodule
